>>> hw/rtl/pnf_pkg.sv
// Shared types, constants and a helper function for the padded number formatter.
package pnf_pkg;

  localparam int VALUE_W     = 32;
  localparam int CONV_W      = 2;
  localparam int PAD_W       = 4;
  localparam int CHAR_W      = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int HEX_DIGITS  = VALUE_W / DIGIT_W;
  localparam int CONV_STEPS  = VALUE_W;
  localparam int STEP_W      = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PAD_W-1:0]  MAX_PAD    = 4'd9;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

  typedef enum logic [CONV_W-1:0] {
    CONV_SDEC = 2'd0,
    CONV_UDEC = 2'd1,
    CONV_HEX  = 2'd2,
    CONV_RSVD = 2'd3
  } conv_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIZE,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               hex;
    logic [PAD_W-1:0]   pad;
    logic               zpad;
  } pnf_item_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_RADIX) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOWA + CHAR_W'(d - DEC_RADIX);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/pnf_front.sv
// Front end: accepts numbers, derives sign, magnitude, radix and pad, pushes to the queue.
module pnf_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pnf_pkg::VALUE_W-1:0] in_value,
  input  logic [pnf_pkg::CONV_W-1:0]  in_conversion,
  input  logic [pnf_pkg::PAD_W-1:0]   in_pad_width,
  input  logic                        in_zero_pad,
  input  logic                        q_full,
  output logic                        q_push,
  output pnf_pkg::pnf_item_t          q_data
);
  import pnf_pkg::*;

  conv_t conv;

  assign conv     = conv_t'(in_conversion);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.neg  = (conv == CONV_SDEC) && in_value[VALUE_W-1];
    q_data.mag  = q_data.neg ? (~in_value + VALUE_W'(1)) : in_value;
    q_data.hex  = (conv == CONV_HEX);
    q_data.pad  = (in_pad_width > MAX_PAD) ? MAX_PAD : in_pad_width;
    q_data.zpad = in_zero_pad;
  end

endmodule

>>> hw/rtl/pnf_queue.sv
// Short queue of classified numbers between the front and back ends.
module pnf_queue #(
  parameter int DEPTH = pnf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pnf_pkg::pnf_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output pnf_pkg::pnf_item_t pop_data
);
  import pnf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pnf_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/pnf_back.sv
// Back end: shift-add binary to decimal conversion, sizing and character emission.
module pnf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  pnf_pkg::pnf_item_t         q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pnf_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last
);
  import pnf_pkg::*;

  back_state_t       state_r, state_nxt;
  pnf_item_t         item_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [VALUE_W-1:0] bin_r;
  logic [STEP_W-1:0] step_r;
  logic [PAD_W-1:0]  pad_left_r;
  logic              sign_r;
  logic [DIGIT_W-1:0] dig_idx_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r;

  logic              load, conv_step, size, emit, out_free, last_char, conv_done;
  logic [BCD_W-1:0]  bcd_adj;
  logic [DIGIT_W-1:0] digits [NUM_DIGITS];
  logic [DIGIT_W-1:0] top;
  logic [PAD_W-1:0]  text_len;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digits[i] = bcd_r[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  always_comb begin
    top = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        top = DIGIT_W'(i);
      end
    end
    text_len = PAD_W'(top) + PAD_W'(1) + PAD_W'(item_r.neg);
  end

  assign conv_done = (step_r == STEP_W'(CONV_STEPS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign last_char = (pad_left_r == '0) && !sign_r && (dig_idx_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = q_data.hex ? B_SIZE : B_CONV;
        end
      end
      B_CONV: begin
        if (conv_done) begin
          state_nxt = B_SIZE;
        end
      end
      B_SIZE: state_nxt = B_EMIT;
      B_EMIT: begin
        if (out_free && last_char) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    conv_step = 1'b0;
    size      = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      B_IDLE:  load      = q_valid;
      B_CONV:  conv_step = 1'b1;
      B_SIZE:  size      = 1'b1;
      B_EMIT:  emit      = out_free;
      default: load      = 1'b0;
    endcase
  end

  assign q_pop = load;

  always_comb begin
    if (pad_left_r != '0) begin
      out_char_nxt = item_r.zpad ? CHAR_ZERO : CHAR_SPACE;
    end else if (sign_r) begin
      out_char_nxt = CHAR_MINUS;
    end else begin
      out_char_nxt = digit_char(digits[dig_idx_r]);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_data;
      bin_r  <= q_data.mag;
      bcd_r  <= q_data.hex ? BCD_W'(q_data.mag) : '0;
      step_r <= '0;
    end
    if (conv_step) begin
      bcd_r  <= {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_r  <= {bin_r[VALUE_W-2:0], 1'b0};
      step_r <= step_r + STEP_W'(1);
    end
    if (size) begin
      dig_idx_r  <= top;
      sign_r     <= item_r.neg;
      pad_left_r <= (item_r.pad > text_len) ? item_r.pad - text_len : '0;
    end
    if (emit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= last_char;
      if (pad_left_r != '0) begin
        pad_left_r <= pad_left_r - PAD_W'(1);
      end else if (sign_r) begin
        sign_r <= 1'b0;
      end else if (dig_idx_r != '0) begin
        dig_idx_r <= dig_idx_r - DIGIT_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

>>> hw/rtl/padded_number_formatter.sv
// Top level of the padded number formatter.
// Formats a 32-bit value as signed decimal, unsigned decimal or lower-case hex
// text, one ASCII character per output transfer, most significant first, with
// out_last on the final character; pad characters ('0' or ' ') come before any
// '-' sign, and the pad width (saturated at 9) counts the sign. The front end
// takes a number in the cycle it is offered while a two-entry queue has room.
// The back end handles one number at a time: a decimal number passes through a load
// state, the shift-add conversion state and a sizing state, then emits its characters
// (1 to 11) one per output transfer; a hex number skips the converter. The back
// end takes no new number until the last character of the previous one is emitted;
// its 32-step shift-add converter, the emission and any output stalls set the throughput.
module padded_number_formatter #(
  parameter int QUEUE_DEPTH = pnf_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pnf_pkg::VALUE_W-1:0] in_value,
  input  logic [pnf_pkg::CONV_W-1:0]  in_conversion,
  input  logic [pnf_pkg::PAD_W-1:0]   in_pad_width,
  input  logic                        in_zero_pad,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pnf_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last
);
  import pnf_pkg::*;

  pnf_item_t push_data, pop_data;
  logic      push, pop, full, not_empty;

  pnf_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_conversion (in_conversion),
    .in_pad_width  (in_pad_width),
    .in_zero_pad   (in_zero_pad),
    .q_full        (full),
    .q_push        (push),
    .q_data        (push_data)
  );

  pnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  pnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (not_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

>>> hw/rtl/pnf_checker.sv
// Port-level checker for the padded number formatter and its bind.
module pnf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [pnf_pkg::VALUE_W-1:0] in_value,
  input logic [pnf_pkg::CONV_W-1:0]  in_conversion,
  input logic [pnf_pkg::PAD_W-1:0]   in_pad_width,
  input logic                        in_zero_pad,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pnf_pkg::CHAR_W-1:0]  out_char,
  input logic                        out_last
);
  import pnf_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_char) && $stable(out_last))
    else $error("output payload changed while stalled");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char == CHAR_SPACE) || (out_char == CHAR_MINUS) ||
                  ((out_char >= CHAR_ZERO) && (out_char <= 8'h39)) ||
                  ((out_char >= CHAR_LOWA) && (out_char <= 8'h66)))
    else $error("character outside the formatter's set");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == CHAR_MINUS || out_char == CHAR_SPACE) |-> !out_last)
    else $error("number ends in a sign or pad character");

endmodule

bind padded_number_formatter pnf_checker u_pnf_checker (.*);

>>> tb/pnf_checker.sv
// Checker for the padded number formatter: predicts the character stream and compares it.
module pnf_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [pnf_pkg::VALUE_W-1:0] in_value,
  input  logic [pnf_pkg::CONV_W-1:0]  in_conversion,
  input  logic [pnf_pkg::PAD_W-1:0]   in_pad_width,
  input  logic                        in_zero_pad,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [pnf_pkg::CHAR_W-1:0]  out_char,
  input  logic                        out_last,
  output int                          pending_chars,
  output int                          error_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import pnf_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_entry_t;

  char_entry_t expected_chars[$];

  initial begin
    pending_chars = 0;
    error_count   = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_chars(input logic [VALUE_W-1:0] value,
                                        input logic [CONV_W-1:0] conv,
                                        input logic [PAD_W-1:0] pad_in,
                                        input logic zpad);
    logic [VALUE_W-1:0] mag;
    logic [PAD_W-1:0]   pad;
    logic [DIGIT_W-1:0] d;
    logic [CHAR_W-1:0]  text[12];
    logic [CHAR_W-1:0]  rev[12];
    int unsigned        radix;
    int                 nd;
    int                 len;
    int                 fill;
    char_entry_t        ent;
    pad   = (pad_in > MAX_PAD) ? MAX_PAD : pad_in;
    mag   = value;
    radix = 10;
    len   = 0;
    nd    = 0;
    if (conv == CONV_SDEC && value[VALUE_W-1]) begin
      text[len] = CHAR_MINUS;
      len++;
      mag = ~value + 1'b1;
    end else if (conv == CONV_HEX) begin
      radix = 16;
    end
    do begin
      d = DIGIT_W'(mag % radix);
      rev[nd] = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_LOWA + CHAR_W'(d - 4'd10);
      nd++;
      mag = mag / radix;
    end while (mag != 0);
    for (int i = nd - 1; i >= 0; i--) begin
      text[len] = rev[i];
      len++;
    end
    fill = (int'(pad) > len) ? int'(pad) - len : 0;
    for (int i = 0; i < fill; i++) begin
      ent.code = zpad ? CHAR_ZERO : CHAR_SPACE;
      ent.last = 1'b0;
      expected_chars.push_back(ent);
    end
    for (int i = 0; i < len; i++) begin
      ent.code = text[i];
      ent.last = (i == len - 1);
      expected_chars.push_back(ent);
    end
  endfunction

  always @(posedge clk) begin
    char_entry_t exp_ent;
    if (!rst_n) begin
      expected_chars.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_chars(in_value, in_conversion, in_pad_width, in_zero_pad);
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_error($sformatf("unexpected char %h last %b", out_char, out_last));
        end else begin
          exp_ent = expected_chars.pop_front();
          if (out_char !== exp_ent.code) begin
            report_error($sformatf("out_char got %h expected %h", out_char, exp_ent.code));
          end
          if (out_last !== exp_ent.last) begin
            report_error($sformatf("out_last got %b expected %b on char %h",
                                   out_last, exp_ent.last, exp_ent.code));
          end
        end
      end
    end
    pending_chars <= expected_chars.size();
  end

endmodule

>>> tb/tb.sv
// Top of the padded number formatter testbench: clock, reset, stimulus and verdict.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pnf_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value;
  logic [CONV_W-1:0]  in_conversion;
  logic [PAD_W-1:0]   in_pad_width;
  logic               in_zero_pad;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  int                 pending_chars;
  int                 error_count;

  int send_max;
  int recv_max;
  bit hold_req;

  padded_number_formatter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_conversion(in_conversion),
    .in_pad_width (in_pad_width),
    .in_zero_pad  (in_zero_pad),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last)
  );

  pnf_scoreboard u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_conversion(in_conversion),
    .in_pad_width (in_pad_width),
    .in_zero_pad  (in_zero_pad),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last),
    .pending_chars(pending_chars),
    .error_count  (error_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall per transfer, one long hold-off on request
  initial begin
    int stall_cycles;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_cycles = 300;
      end else begin
        stall_cycles = (recv_max == 0) ? 0 : $urandom_range(0, recv_max);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_number(input logic [VALUE_W-1:0] value, input conv_t conv,
                             input logic [PAD_W-1:0] pad, input logic zpad);
    int gap;
    gap = (send_max == 0) ? 0 : $urandom_range(0, send_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= value;
    in_conversion <= conv;
    in_pad_width  <= pad;
    in_zero_pad   <= zpad;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] corner[12];
    logic [VALUE_W-1:0] v;
    corner = '{32'd0, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
               32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0fffffff, 32'h10000000};
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = corner[$urandom_range(0, 11)];
      2: v = -$urandom_range(1, 1000);
      3: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin
    int phase_send[5];
    int phase_recv[5];
    phase_send = '{17, 0, 0, 17, 4};
    phase_recv = '{17, 0, 17, 0, 6};
    send_max = 5;
    recv_max = 5;
    hold_req = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    in_conversion <= CONV_SDEC;
    in_pad_width  <= '0;
    in_zero_pad   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_number(32'd0,         CONV_SDEC, 4'd0,  1'b0);
    send_number(32'd0,         CONV_HEX,  4'd5,  1'b1);
    send_number(32'd0,         CONV_UDEC, 4'd9,  1'b0);
    send_number(32'hfffffffb,  CONV_SDEC, 4'd4,  1'b1);
    send_number(32'hfffffffb,  CONV_SDEC, 4'd4,  1'b0);
    send_number(32'h80000000,  CONV_SDEC, 4'd0,  1'b0);
    send_number(32'h80000000,  CONV_UDEC, 4'd0,  1'b1);
    send_number(32'h80000000,  CONV_HEX,  4'd0,  1'b0);
    send_number(32'hffffffff,  CONV_SDEC, 4'd3,  1'b1);
    send_number(32'hffffffff,  CONV_UDEC, 4'd10, 1'b0);
    send_number(32'hffffffff,  CONV_HEX,  4'd15, 1'b1);
    send_number(32'h7fffffff,  CONV_SDEC, 4'd9,  1'b0);
    send_number(32'd12345,     CONV_RSVD, 4'd7,  1'b1);
    send_number(32'hfffffffb,  CONV_RSVD, 4'd0,  1'b0);
    send_number(32'd1000000000, CONV_UDEC, 4'd1, 1'b0);
    send_number(32'hdeadbeef,  CONV_HEX,  4'd12, 1'b0);
    send_number(32'habcdef01,  CONV_HEX,  4'd8,  1'b1);
    send_number(32'd7,         CONV_HEX,  4'd9,  1'b0);
    send_number(32'd9,         CONV_SDEC, 4'd2,  1'b1);
    send_number(32'd10,        CONV_UDEC, 4'd2,  1'b0);

    for (int p = 0; p < 5; p++) begin
      send_max = phase_send[p];
      recv_max = phase_recv[p];
      if (p == 1) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < 70; n++) begin
        send_number(pick_value(), conv_t'($urandom_range(0, 3)),
                    PAD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
